FILE: sv/rte_pkg.sv
// shared types, register indexes and saturating time arithmetic for the rtt timeout estimator
package rte_pkg;

  localparam int TimeW = 32;
  localparam int CfgAddrW = 5;
  localparam int ShlGuardW = 16;

  typedef logic [TimeW-1:0] tval_t;
  typedef logic [2:0] reg_idx_t;

  localparam reg_idx_t RegLogInvAlpha = 3'd0;
  localparam reg_idx_t RegLogInvBeta = 3'd1;
  localparam reg_idx_t RegLogK = 3'd2;
  localparam reg_idx_t RegMinTimeout = 3'd3;
  localparam reg_idx_t RegInitTimeout = 3'd4;

  localparam logic [63:0] TMax64 = {64{1'b1}} >> (64 - TimeW);
  localparam tval_t TMax = tval_t'(TMax64);

  localparam logic [4:0] ResetLogInvAlpha = 5'd3;
  localparam logic [4:0] ResetLogInvBeta = 5'd2;
  localparam logic [3:0] ResetLogK = 4'd2;
  localparam logic [31:0] ResetMinTimeout = 32'd1000;
  localparam logic [31:0] ResetInitTimeout = 32'd3000;

  function automatic tval_t clamp_time(input logic [31:0] v);
    logic [63:0] v64;
    v64 = {32'b0, v};
    if (v64 > TMax64) begin
      return TMax;
    end
    return v64[TimeW-1:0];
  endfunction

  function automatic logic [31:0] to_out(input tval_t v);
    logic [63:0] w;
    w = 64'(v);
    return w[31:0];
  endfunction

  function automatic tval_t sat_add(input tval_t a, input tval_t b);
    logic [TimeW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s[TimeW]) begin
      return TMax;
    end
    return s[TimeW-1:0];
  endfunction

  // shift amount stays below ShlGuardW, so lost bits land in the guard field
  function automatic tval_t sat_shl(input tval_t v, input logic [3:0] s);
    logic [TimeW+ShlGuardW-1:0] w;
    w = {{ShlGuardW{1'b0}}, v} << s;
    if (w[TimeW+ShlGuardW-1:TimeW] != '0) begin
      return TMax;
    end
    return w[TimeW-1:0];
  endfunction

  function automatic tval_t floor_at(input tval_t v, input tval_t f);
    return (v < f) ? f : v;
  endfunction

endpackage

FILE: sv/rtt_timeout_estimator.sv
// rtt timeout estimator: smoothed rtt, mean deviation and retransmission timeout
// Each transaction on the slave side is either an acknowledgement carrying an rtt
// sample (tuser = 0) or a retransmission timeout event (tuser = 1), and yields exactly
// one result transaction with the timeout, smoothed rtt and deviation after the event.
// Samples whose segment was retransmitted (sent_once = 0) leave the state unchanged.
// An item passes an input register and then the update logic into the result register,
// and one item is taken every cycle while the result side does not stall, set by the single
// state update loop that closes through the estimate registers. The configuration port
// must be written only while no transaction is in flight; the block itself does not enforce
// this. Writing initial_timeout before the first counted sample also reloads the timeout.
module rtt_timeout_estimator (
  input  logic        clk_i,
  input  logic        rst_ni,
  // slave side
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [39:0] s_axis_tdata_i,  // rtt_sample[31:0], sent_once[32], zero pad
  input  logic        s_axis_tuser_i,  // func
  // master side
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [95:0] m_axis_tdata_o,  // timeout[31:0], smoothed_rtt[63:32], rtt_variance[95:64]
  // configuration
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [rte_pkg::CfgAddrW-1:0] paddr_i,
  input  logic [31:0] pwdata_i,
  output logic [31:0] prdata_o,
  output logic        pready_o
);

  logic [4:0]  log_inv_alpha_q;
  logic [4:0]  log_inv_beta_q;
  logic [3:0]  log_k_q;
  logic [31:0] min_timeout_q;
  logic [31:0] init_timeout_q;

  rte_pkg::tval_t srtt_q, srtt_d;
  rte_pkg::tval_t var_q, var_d;
  rte_pkg::tval_t rto_q, rto_d;
  logic           have_q, have_d;

  logic        in_valid_q;
  logic        in_func_q;
  logic        in_once_q;
  logic [31:0] in_rtt_q;

  logic        out_valid_q;
  logic [95:0] out_data_q;

  logic           advance;
  logic           in_take;
  logic           cfg_wr;
  rte_pkg::reg_idx_t cfg_idx;
  rte_pkg::tval_t rtt;
  rte_pkg::tval_t floor_v;
  rte_pkg::tval_t diff;

  assign pready_o = 1'b1;
  assign cfg_idx  = paddr_i[4:2];
  assign cfg_wr   = psel_i && penable_i && pwrite_i;

  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;
  assign in_take         = s_axis_tvalid_i && s_axis_tready_o;

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  always_comb begin
    case (cfg_idx)
      rte_pkg::RegLogInvAlpha: prdata_o = {27'b0, log_inv_alpha_q};
      rte_pkg::RegLogInvBeta:  prdata_o = {27'b0, log_inv_beta_q};
      rte_pkg::RegLogK:        prdata_o = {28'b0, log_k_q};
      rte_pkg::RegMinTimeout:  prdata_o = min_timeout_q;
      rte_pkg::RegInitTimeout: prdata_o = init_timeout_q;
      default:                 prdata_o = 32'b0;
    endcase
  end

  // estimate update
  always_comb begin
    rtt     = rte_pkg::clamp_time(in_rtt_q);
    floor_v = rte_pkg::clamp_time(min_timeout_q);
    diff    = (srtt_q > rtt) ? (srtt_q - rtt) : (rtt - srtt_q);
    srtt_d  = srtt_q;
    var_d   = var_q;
    rto_d   = rto_q;
    have_d  = have_q;
    if (in_func_q) begin
      rto_d = rte_pkg::floor_at(rte_pkg::sat_shl(rto_q, 4'd1), floor_v);
    end else if (in_once_q) begin
      if (!have_q) begin
        srtt_d = rtt;
        var_d  = rtt >> 1;
        have_d = 1'b1;
      end else begin
        var_d  = rte_pkg::sat_add(var_q - (var_q >> log_inv_beta_q), diff >> log_inv_beta_q);
        srtt_d = rte_pkg::sat_add(srtt_q - (srtt_q >> log_inv_alpha_q),
                                  rtt >> log_inv_alpha_q);
      end
      rto_d = rte_pkg::floor_at(rte_pkg::sat_add(srtt_d, rte_pkg::sat_shl(var_d, log_k_q)),
                                floor_v);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      log_inv_alpha_q <= rte_pkg::ResetLogInvAlpha;
      log_inv_beta_q  <= rte_pkg::ResetLogInvBeta;
      log_k_q         <= rte_pkg::ResetLogK;
      min_timeout_q   <= rte_pkg::ResetMinTimeout;
      init_timeout_q  <= rte_pkg::ResetInitTimeout;
      srtt_q          <= '0;
      var_q           <= '0;
      rto_q           <= rte_pkg::clamp_time(rte_pkg::ResetInitTimeout);
      have_q          <= 1'b0;
      in_valid_q      <= 1'b0;
      out_valid_q     <= 1'b0;
    end else begin
      if (cfg_wr) begin
        case (cfg_idx)
          rte_pkg::RegLogInvAlpha: log_inv_alpha_q <= pwdata_i[4:0];
          rte_pkg::RegLogInvBeta:  log_inv_beta_q  <= pwdata_i[4:0];
          rte_pkg::RegLogK:        log_k_q         <= pwdata_i[3:0];
          rte_pkg::RegMinTimeout:  min_timeout_q   <= pwdata_i;
          rte_pkg::RegInitTimeout: begin
            init_timeout_q <= pwdata_i;
            if (!have_q) begin
              rto_q <= rte_pkg::clamp_time(pwdata_i);
            end
          end
          default: ;
        endcase
      end
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        srtt_q      <= srtt_d;
        var_q       <= var_d;
        rto_q       <= rto_d;
        have_q      <= have_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_func_q <= s_axis_tuser_i;
      in_once_q <= s_axis_tdata_i[32];
      in_rtt_q  <= s_axis_tdata_i[31:0];
    end
    if (advance) begin
      out_data_q <= {rte_pkg::to_out(var_d), rte_pkg::to_out(srtt_d), rte_pkg::to_out(rto_d)};
    end
  end

endmodule

FILE: bench/rtt_estimate_check.sv
// event kinds and the checker that predicts and compares rtt estimator results
`timescale 1ns / 100ps

package rte_bench_pkg;

  typedef enum logic {EvAck = 1'b0, EvTimeout = 1'b1} event_kind_t;

endpackage

module rtt_estimate_check
  import rte_pkg::*;
  import rte_bench_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_i,
  input  logic [39:0] s_axis_tdata_i,  // rtt_sample[31:0], sent_once[32], zero pad
  input  logic        s_axis_tuser_i,  // func
  input  logic        m_axis_tvalid_i,
  input  logic        m_axis_tready_i,
  input  logic [95:0] m_axis_tdata_i,  // timeout[31:0], smoothed_rtt[63:32], rtt_variance[95:64]
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [CfgAddrW-1:0] paddr_i,
  input  logic [31:0] pwdata_i,
  input  logic        pready_i,
  output int          mismatch_count_o,
  output int          pending_o
);

  typedef struct packed {
    tval_t dev;
    tval_t srtt;
    tval_t rto;
  } estimate_t;

  logic [4:0] alpha_shift;
  logic [4:0] beta_shift;
  logic [3:0] k_shift;
  tval_t      min_rto;
  tval_t      init_rto;

  tval_t srtt_q;
  tval_t dev_q;
  tval_t rto_q;
  logic  est_valid;

  estimate_t expected_estimates[$];
  estimate_t want;
  estimate_t got;
  int        failures;

  function automatic tval_t add_sat(tval_t a, tval_t b);
    logic [TimeW:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[TimeW] ? TMax : sum[TimeW-1:0];
  endfunction

  function automatic tval_t shl_sat(tval_t v, int unsigned s);
    if (v == '0) begin
      return '0;
    end
    if (s >= TimeW || v > (TMax >> s)) begin
      return TMax;
    end
    return v << s;
  endfunction

  function automatic tval_t at_least_min(tval_t v);
    return (v < min_rto) ? min_rto : v;
  endfunction

  function automatic void write_setting(reg_idx_t idx, logic [31:0] value);
    case (idx)
      RegLogInvAlpha: alpha_shift = value[4:0];
      RegLogInvBeta: beta_shift = value[4:0];
      RegLogK: k_shift = value[3:0];
      RegMinTimeout: min_rto = value;
      RegInitTimeout: begin
        init_rto = value;
        if (!est_valid) begin
          rto_q = value;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void update_estimate(event_kind_t kind, tval_t rtt, logic once);
    tval_t diff;
    if (kind == EvTimeout) begin
      rto_q = at_least_min(shl_sat(rto_q, 1));
    end else if (once) begin
      if (!est_valid) begin
        srtt_q = rtt;
        dev_q = rtt >> 1;
        est_valid = 1'b1;
      end else begin
        diff = (srtt_q > rtt) ? srtt_q - rtt : rtt - srtt_q;
        dev_q = add_sat(dev_q - (dev_q >> beta_shift), diff >> beta_shift);
        srtt_q = add_sat(srtt_q - (srtt_q >> alpha_shift), rtt >> alpha_shift);
      end
      rto_q = at_least_min(add_sat(srtt_q, shl_sat(dev_q, k_shift)));
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_shift = ResetLogInvAlpha;
      beta_shift = ResetLogInvBeta;
      k_shift = ResetLogK;
      min_rto = ResetMinTimeout;
      init_rto = ResetInitTimeout;
      srtt_q = '0;
      dev_q = '0;
      rto_q = ResetInitTimeout;
      est_valid = 1'b0;
      expected_estimates.delete();
      failures = 0;
      mismatch_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        write_setting(reg_idx_t'(paddr_i[CfgAddrW-1:2]), pwdata_i);
      end
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got = m_axis_tdata_i;
        if (expected_estimates.size() == 0) begin
          if (failures < 10) begin
            $display("unexpected result: timeout %0d srtt %0d var %0d",
                     got.rto, got.srtt, got.dev);
          end
          failures++;
        end else begin
          want = expected_estimates.pop_front();
          if (got != want) begin
            if (failures < 10) begin
              $display("result mismatch: timeout %0d/%0d srtt %0d/%0d var %0d/%0d (exp/got)",
                       want.rto, got.rto, want.srtt, got.srtt, want.dev, got.dev);
            end
            failures++;
          end
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        update_estimate(event_kind_t'(s_axis_tuser_i), s_axis_tdata_i[31:0],
                        s_axis_tdata_i[32]);
        expected_estimates.push_back('{dev: dev_q, srtt: srtt_q, rto: rto_q});
      end
      mismatch_count_o <= failures;
      pending_o <= expected_estimates.size();
    end
  end

endmodule

FILE: bench/rtt_timeout_estimator_test.sv
// top of the rtt timeout estimator testbench: clock, reset, stimulus and verdict
`timescale 1ns / 100ps

module rtt_timeout_estimator_test;
  import rte_pkg::*;
  import rte_bench_pkg::*;

  localparam int StallLimit = 3000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [95:0] m_tdata;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [CfgAddrW-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  logic        calm = 1'b0;
  int          stall_cycles = 0;
  int          mismatches;
  int          pending;
  int unsigned rtt_base;

  rtt_timeout_estimator uut (
    .clk_i(clk),
    .rst_ni(rst_n),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .s_axis_tdata_i(s_tdata),
    .s_axis_tuser_i(s_tuser),
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o(m_tdata),
    .psel_i(psel),
    .penable_i(penable),
    .pwrite_i(pwrite),
    .paddr_i(paddr),
    .pwdata_i(pwdata),
    .prdata_o(prdata),
    .pready_o(pready)
  );

  rtt_estimate_check checker_i (
    .clk_i(clk),
    .rst_ni(rst_n),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_i(s_tready),
    .s_axis_tdata_i(s_tdata),
    .s_axis_tuser_i(s_tuser),
    .m_axis_tvalid_i(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_i(m_tdata),
    .psel_i(psel),
    .penable_i(penable),
    .pwrite_i(pwrite),
    .paddr_i(paddr),
    .pwdata_i(pwdata),
    .pready_i(pready),
    .mismatch_count_o(mismatches),
    .pending_o(pending)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    m_tready <= calm || ($urandom_range(99) >= 34);
  end

  always @(posedge clk) begin
    if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("rtt_timeout_estimator_test: FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic send_event(event_kind_t kind, logic [31:0] rtt, logic once);
    while (!calm && $urandom_range(99) < 34) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= kind;
    s_tdata <= {7'b0, once, rtt};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // drop valid and wait until every result is back
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic program_phase(int unsigned phase);
    logic [31:0] alpha, beta, k, min_to, init_to;
    case (phase)
      0: begin
        alpha = 0; beta = 0; k = 0; min_to = 0; init_to = 0;
      end
      1: begin
        alpha = 31; beta = 31; k = 8; min_to = '1; init_to = '1;
      end
      2: begin
        alpha = 3; beta = 2; k = 2; min_to = 1000; init_to = 3000;
      end
      default: begin
        alpha = $urandom_range(0, 31) | ($urandom & 32'hFFFF_FFE0);
        beta = $urandom_range(0, 31) | ($urandom & 32'hFFFF_FFE0);
        k = $urandom_range(0, 8) | ($urandom & 32'hFFFF_FFF0);
        case ($urandom_range(3))
          0: min_to = 0;
          1: min_to = $urandom_range(1, 5000);
          2: min_to = $urandom_range(5000, 100000);
          default: min_to = $urandom;
        endcase
        init_to = $urandom;
      end
    endcase
    write_reg(RegLogInvAlpha, alpha);
    write_reg(RegLogInvBeta, beta);
    write_reg(RegLogK, k);
    write_reg(RegMinTimeout, min_to);
    write_reg(RegInitTimeout, init_to);
  endtask

  task automatic random_events(int unsigned count);
    event_kind_t kind;
    logic [31:0] rtt;
    logic        once;
    rtt_base = $urandom_range(20, 20000);
    repeat (count) begin
      kind = ($urandom_range(99) < 20) ? EvTimeout : EvAck;
      once = ($urandom_range(99) < 85);
      case ($urandom_range(9))
        0: rtt = '0;
        1: rtt = '1;
        2: rtt = $urandom;
        default: rtt = rtt_base / 2 + $urandom_range(0, rtt_base);
      endcase
      send_event(kind, rtt, once);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings, no estimate yet
    send_event(EvTimeout, '1, 1'b1);
    send_event(EvAck, 32'd12345, 1'b0);
    settle();
    write_reg(RegMinTimeout, 32'd0);
    write_reg(RegInitTimeout, 32'd0);
    send_event(EvTimeout, 32'd0, 1'b0);
    settle();
    write_reg(RegInitTimeout, '1);
    send_event(EvTimeout, 32'd55, 1'b1);
    settle();
    write_reg(RegInitTimeout, 32'd3000);
    write_reg(RegMinTimeout, 32'd1000);
    send_event(EvTimeout, 32'd0, 1'b0);

    // first sample, then extremes of the update
    send_event(EvAck, 32'd0, 1'b1);
    send_event(EvAck, '1, 1'b1);
    send_event(EvAck, 32'd0, 1'b0);
    send_event(EvTimeout, 32'd0, 1'b0);
    send_event(EvAck, 32'd1000, 1'b1);
    send_event(EvAck, 32'd1000, 1'b1);
    send_event(EvTimeout, '1, 1'b1);
    send_event(EvTimeout, 32'd7, 1'b0);
    send_event(EvAck, 32'd0, 1'b1);
    settle();

    // writes to unused addresses and an initial timeout with an estimate in place
    for (int j = 1; j <= 3; j++) begin
      write_reg(RegInitTimeout + reg_idx_t'(j), $urandom);
    end
    write_reg(RegInitTimeout, 32'd777);
    write_reg(RegLogK, 32'd8);
    write_reg(RegLogInvAlpha, 32'd0);
    write_reg(RegLogInvBeta, 32'd31);
    send_event(EvAck, 32'd500, 1'b1);
    send_event(EvAck, '1, 1'b1);
    send_event(EvTimeout, 32'd0, 1'b1);
    send_event(EvAck, 32'd123, 1'b1);
    settle();

    for (int unsigned phase = 0; phase < 8; phase++) begin
      program_phase(phase);
      calm <= (phase == 2);
      random_events(150);
      settle();
    end

    if (mismatches == 0 && pending == 0) begin
      $display("rtt_timeout_estimator_test: PASS");
    end else begin
      $display("rtt_timeout_estimator_test: FAIL");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/rte_pkg.sv
sv/rtt_timeout_estimator.sv
bench/rtt_estimate_check.sv
bench/rtt_timeout_estimator_test.sv
